/* hdl/cswt_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the counter semaphore with waiter table
// no dependencies

package cswt_pkg;

	localparam int WAIT_SLOTS = 16;
	localparam int COUNT_BITS = 32;

	localparam int SLOT_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
	localparam int FILL_W = $clog2(WAIT_SLOTS + 1);

	// stream payload widths, rounded up to whole bytes
	localparam int IN_DATA_W  = ((3 + 32 + 8 + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((8 + 32 + 2 + 7) / 8) * 8;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [7:0]            ident_t;

	// request codes
	localparam logic [2:0] MODE_ADD     = 3'd0;
	localparam logic [2:0] MODE_SET     = 3'd1;
	localparam logic [2:0] MODE_WAIT_EQ = 3'd2;
	localparam logic [2:0] MODE_TAKE    = 3'd3;
	localparam logic [2:0] MODE_READ    = 3'd4;
	localparam logic [2:0] MODE_CANCEL  = 3'd5;

	// response status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_QUEUED    = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	// result kinds
	localparam logic KIND_WAKE = 1'b0;
	localparam logic KIND_RESP = 1'b1;

	// one waiter table entry
	typedef struct packed {
		logic   is_take;
		count_t amount;
		ident_t ident;
	} entry_t;

	typedef struct packed {
		logic   en;
		slot_t  addr;
		entry_t data;
	} ram_wr_t;

	typedef struct packed {
		logic  en;
		slot_t addr;
	} ram_rd_t;

endpackage

/* hdl/cswt_wait_ram.sv */
`timescale 1ns / 1ps
// waiter table storage: one write port, one read port, registered read data
// depends on cswt_pkg

module cswt_wait_ram (
	input  logic              clk,
	input  cswt_pkg::ram_wr_t wr,
	input  cswt_pkg::ram_rd_t rd,
	output cswt_pkg::entry_t  rd_data
);

	cswt_pkg::entry_t mem [cswt_pkg::WAIT_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* hdl/counter_semaphore_wait_table.sv */
`timescale 1ns / 1ps
// top level: counting semaphore with an arrival-ordered waiter table
// depends on cswt_pkg and cswt_wait_ram
// sequence: read, queued and refused requests go through ST_FETCH and ST_LOAD to their response;
//   add, set, immediate take and cancel first run one pass over the table, then each wake notice
//   and finally the response go through ST_FETCH and ST_LOAD (an output stall holds ST_LOAD)
// throughput: one request at a time, the next taken only back in ST_IDLE after the response loads;
//   the single ram read port, one entry a cycle, sets the pass length
// reset: counter and fill count cleared at once; table contents need no clearing pass,
//   only the first fill entries are ever read

module counter_semaphore_wait_table (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cswt_pkg::IN_DATA_W-1:0]   s_tdata,  // mode[2:0], amount[34:3], waiter_id[42:35]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cswt_pkg::OUT_DATA_W-1:0]  m_tdata,  // woken_id[7:0], counter_value[39:8],
	                                                   // status[41:40]
	output logic [0:0]                       m_tuser,  // kind[0]
	output logic                             m_tlast
);

	// one-hot sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,  // waiting for a request
		ST_PASS  = 4'b0010,  // ordered walk over the table with compaction
		ST_FETCH = 4'b0100,  // wake buffer read in flight
		ST_LOAD  = 4'b1000   // hand a notice or the response to the output register
	} state_t;

	state_t            state_q;
	cswt_pkg::count_t  count_q;    // counter, also the running value during a pass
	cswt_pkg::fill_t   fill_q;     // number of valid entries, always a prefix
	logic [2:0]        mode_q;
	cswt_pkg::ident_t  id_q;
	logic [1:0]        status_q;
	cswt_pkg::fill_t   nwake_q;    // wakes collected in this pass
	cswt_pkg::fill_t   emit_q;     // wakes already sent
	cswt_pkg::fill_t   rd_ptr_q;   // next table entry to read
	cswt_pkg::fill_t   wr_ptr_q;   // next compacted position
	logic              val_s1;     // read data of the previous cycle is live
	logic              found_q;    // cancel already removed its entry

	// woken identifiers, held until the pass has the final counter value
	cswt_pkg::ident_t  wbuf [cswt_pkg::WAIT_SLOTS];
	cswt_pkg::ident_t  wbuf_rd_q;

	// output register
	logic              m_tvalid_q;
	logic              out_kind_q;
	cswt_pkg::ident_t  out_id_q;
	logic [31:0]       out_count_q;
	logic [1:0]        out_status_q;
	logic              out_last_q;

	// request fields
	logic [2:0]        in_mode;
	cswt_pkg::count_t  in_amt;
	cswt_pkg::ident_t  in_id;
	logic              accept;

	logic              need_queue;
	logic              table_full;
	logic              wake_s1;
	logic              out_free;
	logic              load_out;
	logic              more_wakes;

	cswt_pkg::ram_wr_t ram_wr;
	cswt_pkg::ram_rd_t ram_rd;
	cswt_pkg::entry_t  ram_rdata;

	assign in_mode = s_tdata[2:0];
	assign in_amt  = cswt_pkg::count_t'(s_tdata[34:3]);
	assign in_id   = s_tdata[42:35];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// request that cannot finish now goes into the table, or is refused with STAT_FULL when it is full
	assign need_queue = ((in_mode == cswt_pkg::MODE_WAIT_EQ) && (count_q != in_amt))
	                 || ((in_mode == cswt_pkg::MODE_TAKE) && (count_q < in_amt));
	assign table_full = (fill_q == cswt_pkg::fill_t'(cswt_pkg::WAIT_SLOTS));

	assign out_free   = !m_tvalid_q || m_tready;
	assign load_out   = (state_q == ST_LOAD) && out_free;
	assign more_wakes = (emit_q < nwake_q);

	cswt_wait_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_rdata)
	);

	// table port control: enqueue on accept, read ahead and write back survivors in a pass
	always_comb begin
		ram_wr      = '0;
		ram_rd      = '0;
		wake_s1     = 1'b0;
		if (accept && need_queue && !table_full) begin
			ram_wr.en           = 1'b1;
			ram_wr.addr         = fill_q[cswt_pkg::SLOT_W-1:0];
			ram_wr.data.is_take = (in_mode == cswt_pkg::MODE_TAKE);
			ram_wr.data.amount  = in_amt;
			ram_wr.data.ident   = in_id;
		end
		if (state_q == ST_PASS) begin
			ram_rd.en   = (rd_ptr_q < fill_q);
			ram_rd.addr = rd_ptr_q[cswt_pkg::SLOT_W-1:0];
			if (val_s1) begin
				if (mode_q == cswt_pkg::MODE_CANCEL) begin
					wake_s1 = !found_q && (ram_rdata.ident == id_q);
				end else if (ram_rdata.is_take) begin
					wake_s1 = (count_q >= ram_rdata.amount);
				end else begin
					wake_s1 = (count_q == ram_rdata.amount);
				end
				// entries that stay slide down over the removed ones
				ram_wr.en   = !wake_s1;
				ram_wr.addr = wr_ptr_q[cswt_pkg::SLOT_W-1:0];
				ram_wr.data = ram_rdata;
			end
		end
	end

	// sequencer and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			fill_q     <= '0;
			mode_q     <= cswt_pkg::MODE_READ;
			id_q       <= '0;
			status_q   <= cswt_pkg::STAT_DONE;
			nwake_q    <= '0;
			emit_q     <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			val_s1     <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a transaction leaving the output register frees it unless a new one loads
			if (m_tvalid_q && m_tready && !load_out) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= in_mode;
						id_q     <= in_id;
						nwake_q  <= '0;
						emit_q   <= '0;
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						val_s1   <= 1'b0;
						found_q  <= 1'b0;
						if (need_queue) begin
							state_q <= ST_FETCH;
							if (table_full) begin
								status_q <= cswt_pkg::STAT_FULL;
							end else begin
								status_q <= cswt_pkg::STAT_QUEUED;
								fill_q   <= fill_q + 1'b1;
							end
						end else begin
							unique case (in_mode)
								cswt_pkg::MODE_ADD: begin
									count_q  <= count_q + in_amt;
									status_q <= cswt_pkg::STAT_DONE;
									state_q  <= ST_PASS;
								end
								cswt_pkg::MODE_SET: begin
									count_q  <= in_amt;
									status_q <= cswt_pkg::STAT_DONE;
									state_q  <= ST_PASS;
								end
								cswt_pkg::MODE_TAKE: begin
									count_q  <= count_q - in_amt;
									status_q <= cswt_pkg::STAT_DONE;
									state_q  <= ST_PASS;
								end
								cswt_pkg::MODE_CANCEL: begin
									status_q <= cswt_pkg::STAT_NOT_FOUND;
									state_q  <= ST_PASS;
								end
								// matching equality wait, read and the unused codes
								default: begin
									status_q <= cswt_pkg::STAT_DONE;
									state_q  <= ST_FETCH;
								end
							endcase
						end
					end
				end
				ST_PASS: begin
					rd_ptr_q <= rd_ptr_q + cswt_pkg::fill_t'(ram_rd.en);
					val_s1   <= ram_rd.en;
					if (val_s1) begin
						if (wake_s1) begin
							if (mode_q == cswt_pkg::MODE_CANCEL) begin
								found_q  <= 1'b1;
								status_q <= cswt_pkg::STAT_DONE;
							end else begin
								if (ram_rdata.is_take) begin
									count_q <= count_q - ram_rdata.amount;
								end
								nwake_q <= nwake_q + 1'b1;
							end
						end else begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
					end
					// last entry evaluated and nothing more to read
					if (!val_s1 && !ram_rd.en) begin
						fill_q  <= wr_ptr_q;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (more_wakes) begin
							emit_q  <= emit_q + 1'b1;
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// wake buffer, written during the pass and read back in order
	always_ff @(posedge clk) begin
		if ((state_q == ST_PASS) && val_s1 && wake_s1 && (mode_q != cswt_pkg::MODE_CANCEL)) begin
			wbuf[nwake_q[cswt_pkg::SLOT_W-1:0]] <= ram_rdata.ident;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FETCH) && more_wakes) begin
			wbuf_rd_q <= wbuf[emit_q[cswt_pkg::SLOT_W-1:0]];
		end
	end

	// output payload; the counter is final once the pass is over
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q <= 32'(count_q);
			if (more_wakes) begin
				out_kind_q   <= cswt_pkg::KIND_WAKE;
				out_id_q     <= wbuf_rd_q;
				out_status_q <= cswt_pkg::STAT_DONE;
				out_last_q   <= 1'b0;
			end else begin
				out_kind_q   <= cswt_pkg::KIND_RESP;
				out_id_q     <= id_q;
				out_status_q <= status_q;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_status_q, out_count_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// the table never holds more entries than it has slots
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cswt_pkg::fill_t'(cswt_pkg::WAIT_SLOTS))
		else $error("waiter fill count beyond table size");

	// compaction writes stay behind the entry being evaluated
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS) && val_s1 |-> wr_ptr_q < rd_ptr_q)
		else $error("write back overtook table reads");

	// a request transaction blocks the next until its response is queued
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second request taken while busy");

	// notices never run past the wakes collected
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) || (state_q == ST_FETCH) |-> emit_q <= nwake_q)
		else $error("wake notice index past collected wakes");

endmodule
